### src/bpua_pkg.sv
// bpua_pkg: shared constants and types for the button press uid action block
// action codes, register map, field widths and the press event struct
// no dependencies
package bpua_pkg;

    // defaults for the top level parameters
    localparam int LONG_PRESS_TICKS_DEF = 10;
    localparam int MAX_UID_BYTES_DEF    = 8;

    // field widths
    localparam int ACT_W      = 4;
    localparam int FIELD_W    = 64;
    localparam int SIZE_W     = 4;
    localparam int APB_DATA_W = 32;
    localparam int APB_ADDR_W = 4;
    localparam int REG_IDX_W  = 2;

    // input op codes
    localparam logic OP_TICK = 1'b0;
    localparam logic OP_LOAD = 1'b1;

    // action codes
    localparam logic [ACT_W-1:0] ACT_NONE      = 4'd0;
    localparam logic [ACT_W-1:0] ACT_RANDOM    = 4'd1;
    localparam logic [ACT_W-1:0] ACT_INC_LEFT  = 4'd2;
    localparam logic [ACT_W-1:0] ACT_INC_RIGHT = 4'd3;
    localparam logic [ACT_W-1:0] ACT_DEC_LEFT  = 4'd4;
    localparam logic [ACT_W-1:0] ACT_DEC_RIGHT = 4'd5;
    localparam logic [ACT_W-1:0] ACT_CYCLE     = 4'd6;
    localparam logic [ACT_W-1:0] ACT_STORE     = 4'd7;
    localparam logic [ACT_W-1:0] ACT_RECALL    = 4'd8;

    // register indexes (byte address 4*index)
    localparam logic [REG_IDX_W-1:0] REG_SHORT_ACTION = 2'd0;
    localparam logic [REG_IDX_W-1:0] REG_LONG_ACTION  = 2'd1;
    localparam logic [REG_IDX_W-1:0] REG_UID_SIZE     = 2'd2;

    localparam logic [SIZE_W-1:0] UID_SIZE_RST = 4'd4;

    // press events raised by the counter for the item in flight
    typedef struct packed {
        logic fire_short;
        logic fire_long;
    } press_evt_t;

endpackage

### src/bpua_press.sv
// bpua_press: pressed tick counter with short and long press detection
// depends on bpua_pkg
module bpua_press #(
    parameter int LONG_PRESS_TICKS = bpua_pkg::LONG_PRESS_TICKS_DEF
) (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  step,
    input  logic                  pressed,
    output bpua_pkg::press_evt_t  evt
);
    import bpua_pkg::*;

    localparam int CNT_W = $clog2(LONG_PRESS_TICKS + 2);
    localparam logic [CNT_W-1:0] LONG_CNT = CNT_W'(LONG_PRESS_TICKS);
    localparam logic [CNT_W-1:0] HELD_CNT = CNT_W'(LONG_PRESS_TICKS + 1);

    logic [CNT_W-1:0] cnt_reg;
    logic [CNT_W-1:0] cnt_next;

    always_comb
    begin
        cnt_next       = cnt_reg;
        evt.fire_short = 1'b0;
        evt.fire_long  = 1'b0;
        if (step)
        begin
            if (pressed)
            begin
                if (cnt_reg < LONG_CNT)
                begin
                    cnt_next = cnt_reg + 1'b1;
                end
                else if (cnt_reg == LONG_CNT)
                begin
                    evt.fire_long = 1'b1;
                    cnt_next      = HELD_CNT;
                end
            end
            else
            begin
                // release after a held-past-long press fires nothing
                evt.fire_short = (cnt_reg != '0) && (cnt_reg <= LONG_CNT);
                cnt_next       = '0;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg <= '0;
        end
        else
        begin
            cnt_reg <= cnt_next;
        end
    end

    a_cnt_range: assert property (@(posedge clk) disable iff (!rst_n)
        cnt_reg <= HELD_CNT)
        else $error("press count beyond held value");

    a_long_holds: assert property (@(posedge clk) disable iff (!rst_n)
        evt.fire_long |=> cnt_reg == HELD_CNT)
        else $error("long press did not park the count");

    a_short_clears: assert property (@(posedge clk) disable iff (!rst_n)
        evt.fire_short |=> cnt_reg == '0 && !evt.fire_long)
        else $error("short press did not clear the count");

endmodule

### src/bpua_uid.sv
// bpua_uid: held uid register with load, random and byte-wise inc/dec actions
// depends on bpua_pkg
module bpua_uid #(
    parameter int MAX_UID_BYTES = bpua_pkg::MAX_UID_BYTES_DEF
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          step,
    input  logic                          load,
    input  logic [8*MAX_UID_BYTES-1:0]    load_value,
    input  logic [8*MAX_UID_BYTES-1:0]    rnd,
    input  logic [bpua_pkg::ACT_W-1:0]    code,
    input  logic [bpua_pkg::SIZE_W-1:0]   uid_size,
    output logic [8*MAX_UID_BYTES-1:0]    uid_next
);
    import bpua_pkg::*;

    localparam int UID_W = 8 * MAX_UID_BYTES;
    localparam logic [SIZE_W-1:0] MAX_BYTES = SIZE_W'(MAX_UID_BYTES);

    logic [UID_W-1:0]         uid_store_reg;
    logic [SIZE_W-1:0]        nbytes;
    logic [MAX_UID_BYTES-1:0] in_use;
    logic [MAX_UID_BYTES-1:0] edge_val;
    logic [MAX_UID_BYTES-1:0] carry;
    logic [UID_W-1:0]         stepped;
    logic                     down;
    logic                     right;

    assign nbytes = (uid_size > MAX_BYTES) ? MAX_BYTES : uid_size;
    assign down   = (code == ACT_DEC_LEFT) || (code == ACT_DEC_RIGHT);
    assign right  = (code == ACT_INC_RIGHT) || (code == ACT_DEC_RIGHT);

    // per byte: does it wrap, and does the carry from the stepped end reach it
    always_comb
    begin
        for (int i = 0; i < MAX_UID_BYTES; i++)
        begin
            in_use[i]   = SIZE_W'(i) < nbytes;
            edge_val[i] = down ? (uid_store_reg[8*i +: 8] == 8'h00)
                               : (uid_store_reg[8*i +: 8] == 8'hFF);
        end
        for (int i = 0; i < MAX_UID_BYTES; i++)
        begin
            carry[i] = in_use[i];
            for (int j = 0; j < MAX_UID_BYTES; j++)
            begin
                if (!right && (j < i))
                begin
                    carry[i] = carry[i] & edge_val[j];
                end
                if (right && (j > i) && in_use[j])
                begin
                    carry[i] = carry[i] & edge_val[j];
                end
            end
            if (carry[i])
            begin
                stepped[8*i +: 8] = down ? uid_store_reg[8*i +: 8] - 8'd1
                                         : uid_store_reg[8*i +: 8] + 8'd1;
            end
            else
            begin
                stepped[8*i +: 8] = uid_store_reg[8*i +: 8];
            end
        end
    end

    always_comb
    begin
        uid_next = uid_store_reg;
        if (load)
        begin
            uid_next = load_value;
        end
        else
        begin
            case (code)
                ACT_RANDOM:
                begin
                    for (int i = 0; i < MAX_UID_BYTES; i++)
                    begin
                        if (in_use[i])
                        begin
                            uid_next[8*i +: 8] = rnd[8*i +: 8];
                        end
                    end
                end
                ACT_INC_LEFT, ACT_INC_RIGHT, ACT_DEC_LEFT, ACT_DEC_RIGHT:
                begin
                    uid_next = stepped;
                end
                default:
                begin
                    uid_next = uid_store_reg;
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            uid_store_reg <= '0;
        end
        else if (step)
        begin
            uid_store_reg <= uid_next;
        end
    end

    a_load_takes: assert property (@(posedge clk) disable iff (!rst_n)
        step && load |=> uid_store_reg == $past(load_value))
        else $error("uid load not taken");

endmodule

### src/button_press_uid_action.sv
// button_press_uid_action: short/long button press detector acting on a held uid
// top level: input register, press counter, uid unit, result register, apb registers
// depends on bpua_pkg, bpua_press, bpua_uid
//
// usage
//   input channel (in_valid/in_stall): one item per transfer; op 0 is a button
//   tick carrying button_pressed, op 1 loads uid_value into the held uid.
//   output channel (out_valid/out_stall): exactly one result per item, in order:
//   action_fired, action_code and the uid after the item (uid_out).
//   path: an accepted item sits in the input register, then moves to the result
//   register when that is free, where it is presented until it transfers.
//   throughput: one item per cycle unless out_stall holds a result; the counter
//   and uid update are combinational between the input and result registers.
//   stall: while out_stall holds a result, the item in the input register waits
//   and in_stall rises; a held result keeps its payload.
//   reset: counter, uid, channel valids and action registers clear; uid_size resets to 4.
//   apb: short_action at 0x0, long_action at 0x4, uid_size at 0x8, 4 bits each;
//   write only while no item is in flight. pready is tied high.
module button_press_uid_action #(
    parameter int LONG_PRESS_TICKS = bpua_pkg::LONG_PRESS_TICKS_DEF,
    parameter int MAX_UID_BYTES    = bpua_pkg::MAX_UID_BYTES_DEF
) (
    input  logic                              clk,
    input  logic                              rst_n,
    // input channel
    input  logic                              in_valid,
    output logic                              in_stall,
    input  logic                              op,
    input  logic                              button_pressed,
    input  logic [bpua_pkg::FIELD_W-1:0]      uid_value,
    input  logic [bpua_pkg::FIELD_W-1:0]      random_value,
    // output channel
    output logic                              out_valid,
    input  logic                              out_stall,
    output logic                              action_fired,
    output logic [bpua_pkg::ACT_W-1:0]        action_code,
    output logic [bpua_pkg::FIELD_W-1:0]      uid_out,
    // configuration
    input  logic                              psel,
    input  logic                              penable,
    input  logic                              pwrite,
    input  logic [bpua_pkg::APB_ADDR_W-1:0]   paddr,
    input  logic [bpua_pkg::APB_DATA_W-1:0]   pwdata,
    output logic [bpua_pkg::APB_DATA_W-1:0]   prdata,
    output logic                              pready
);
    import bpua_pkg::*;

    localparam int UID_W = 8 * MAX_UID_BYTES;

    // configuration registers
    logic [ACT_W-1:0]     short_action_reg;
    logic [ACT_W-1:0]     long_action_reg;
    logic [SIZE_W-1:0]    uid_size_reg;
    logic [REG_IDX_W-1:0] reg_idx;
    logic                 cfg_wr;

    // input register
    logic             in_valid_reg;
    logic             in_valid_next;
    logic             op_reg;
    logic             pressed_reg;
    logic [UID_W-1:0] uid_value_reg;
    logic [UID_W-1:0] random_reg;

    // result register
    logic             out_valid_reg;
    logic             out_valid_next;
    logic             fired_reg;
    logic [ACT_W-1:0] code_reg;
    logic [UID_W-1:0] uid_out_reg;

    logic             accept;
    logic             advance;
    logic             out_free;
    press_evt_t       press_evt;
    logic [ACT_W-1:0] raw_code;
    logic [ACT_W-1:0] act_code;
    logic [UID_W-1:0] uid_next;

    assign pready  = 1'b1;
    assign reg_idx = paddr[APB_ADDR_W-1:2];
    assign cfg_wr  = psel && penable && pwrite;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            short_action_reg <= ACT_NONE;
            long_action_reg  <= ACT_NONE;
            uid_size_reg     <= UID_SIZE_RST;
        end
        else if (cfg_wr)
        begin
            case (reg_idx)
                REG_SHORT_ACTION: short_action_reg <= pwdata[ACT_W-1:0];
                REG_LONG_ACTION:  long_action_reg  <= pwdata[ACT_W-1:0];
                REG_UID_SIZE:     uid_size_reg     <= pwdata[SIZE_W-1:0];
                default:          ;
            endcase
        end
    end

    always_comb
    begin
        case (reg_idx)
            REG_SHORT_ACTION: prdata = APB_DATA_W'(short_action_reg);
            REG_LONG_ACTION:  prdata = APB_DATA_W'(long_action_reg);
            REG_UID_SIZE:     prdata = APB_DATA_W'(uid_size_reg);
            default:          prdata = '0;
        endcase
    end

    // handshake: the input register moves on whenever the result register is free
    assign out_free = !out_valid_reg || !out_stall;
    assign advance  = in_valid_reg && out_free;
    assign in_stall = in_valid_reg && !out_free;
    assign accept   = in_valid && !in_stall;

    always_comb
    begin
        in_valid_next = in_valid_reg;
        if (accept)
        begin
            in_valid_next = 1'b1;
        end
        else if (advance)
        begin
            in_valid_next = 1'b0;
        end
    end

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (advance)
        begin
            out_valid_next = 1'b1;
        end
        else if (!out_stall)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            in_valid_reg  <= in_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            op_reg        <= op;
            pressed_reg   <= button_pressed;
            uid_value_reg <= uid_value[UID_W-1:0];
            random_reg    <= random_value[UID_W-1:0];
        end
    end

    bpua_press #(
        .LONG_PRESS_TICKS (LONG_PRESS_TICKS)
    ) u_press (
        .clk     (clk),
        .rst_n   (rst_n),
        .step    (advance && (op_reg == OP_TICK)),
        .pressed (pressed_reg),
        .evt     (press_evt)
    );

    // unknown codes behave as none
    always_comb
    begin
        if (press_evt.fire_long)
        begin
            raw_code = long_action_reg;
        end
        else if (press_evt.fire_short)
        begin
            raw_code = short_action_reg;
        end
        else
        begin
            raw_code = ACT_NONE;
        end
        act_code = (raw_code inside {[ACT_RANDOM:ACT_RECALL]}) ? raw_code : ACT_NONE;
    end

    bpua_uid #(
        .MAX_UID_BYTES (MAX_UID_BYTES)
    ) u_uid (
        .clk        (clk),
        .rst_n      (rst_n),
        .step       (advance),
        .load       (op_reg == OP_LOAD),
        .load_value (uid_value_reg),
        .rnd        (random_reg),
        .code       (act_code),
        .uid_size   (uid_size_reg),
        .uid_next   (uid_next)
    );

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            fired_reg   <= act_code != ACT_NONE;
            code_reg    <= act_code;
            uid_out_reg <= uid_next;
        end
    end

    assign out_valid    = out_valid_reg;
    assign action_fired = fired_reg;
    assign action_code  = code_reg;
    assign uid_out      = FIELD_W'(uid_out_reg);

endmodule
